@@ rtl/sgr_pkg.sv @@
package sgr_pkg;

   // Encoder word and channel geometry
   localparam int POSITION_BITS = 21;
   localparam int CHANNELS      = 8;
   localparam int CHAN_BITS     = 3;
   localparam int ANGLE_BITS    = 25;
   localparam int TICK_BITS     = 24;
   localparam int UNIT_BITS     = 16;
   localparam int UNITS_BITS    = 8;
   localparam int BITS_CNT_BITS = $clog2(POSITION_BITS + 1);

   // Angle scaling: code * 360 * 65536 >> POSITION_BITS
   localparam int ANGLE_SCALE      = 360;
   localparam int ANGLE_FRAC_BITS  = 16;
   localparam int ANGLE_PROD_BITS  = POSITION_BITS + 9;
   localparam logic [ANGLE_BITS-1:0] FULL_TURN = 25'd23592960;

   // Configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [UNIT_BITS-1:0]  UNIT_TICKS_RESET  = 16'd62;
   localparam logic [UNITS_BITS-1:0] START_UNITS_RESET = 8'd5;
   localparam logic [UNITS_BITS-1:0] HALF_UNITS_RESET  = 8'd1;
   localparam logic [CHANNELS-1:0]   INVERT_MASK_RESET = 8'd192;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_UNIT_TICKS  = 2'd0,
      CSR_START_UNITS = 2'd1,
      CSR_HALF_UNITS  = 2'd2,
      CSR_INVERT_MASK = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_TICK  = 1'b0,
      OP_START = 1'b1
   } op_type;

   typedef struct packed {
      logic                  is_start;
      logic                  chan_ok;
      logic [CHAN_BITS-1:0]  channel;
      logic [CHANNELS-1:0]   data_lines;
   } cmd_type;

   typedef struct packed {
      logic [UNIT_BITS-1:0]  unit_ticks;
      logic [UNITS_BITS-1:0] start_units;
      logic [UNITS_BITS-1:0] half_units;
      logic [CHANNELS-1:0]   invert_mask;
   } cfg_type;

endpackage

@@ rtl/sgr_if.sv @@
interface sgr_req_if;
   import sgr_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 op;
   logic [CHAN_BITS-1:0] channel;
   logic [CHANNELS-1:0]  data_lines;

   modport source (output valid, op, channel, data_lines, input ready);
   modport sink   (input valid, op, channel, data_lines, output ready);
endinterface

interface sgr_rsp_if;
   import sgr_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [CHANNELS-1:0]      clock_lines;
   logic                     busy_res;
   logic                     done_res;
   logic [CHAN_BITS-1:0]     done_channel;
   logic [POSITION_BITS-1:0] position;
   logic [ANGLE_BITS-1:0]    angle;
   logic                     start_refused;

   modport source (output valid, clock_lines, busy_res, done_res, done_channel, position,
                   angle, start_refused, input ready);
   modport sink   (input valid, clock_lines, busy_res, done_res, done_channel, position,
                   angle, start_refused, output ready);
endinterface

@@ rtl/sgr_front.sv @@
module sgr_front (
   sgr_req_if.sink          req_bus,
   input  logic             queue_full,
   output logic             push,
   output sgr_pkg::cmd_type push_cmd
);
   import sgr_pkg::*;

   assign req_bus.ready = !queue_full;
   assign push          = req_bus.valid && !queue_full;

   // Classify: start or tick, and whether the named channel exists
   always_comb begin
      push_cmd.is_start   = (req_bus.op == OP_START);
      push_cmd.chan_ok    = ({1'b0, req_bus.channel} < (CHAN_BITS + 1)'(CHANNELS));
      push_cmd.channel    = req_bus.channel;
      push_cmd.data_lines = req_bus.data_lines;
   end

endmodule

@@ rtl/sgr_queue.sv @@
module sgr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sgr_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             out_valid,
   output sgr_pkg::cmd_type out_cmd
);
   import sgr_pkg::*;

   localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   cmd_type               slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] ptr);
      logic [PTR_BITS-1:0] nxt;
      nxt = (ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_BITS'(1);
      return nxt;
   endfunction

   assign full      = (count_ff == COUNT_BITS'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/sgr_back.sv @@
module sgr_back (
   input  logic             clock,
   input  logic             reset,
   input  sgr_pkg::cfg_type cfg,
   input  logic             cmd_valid,
   input  sgr_pkg::cmd_type cmd,
   output logic             pop,
   sgr_rsp_if.source        rsp_bus
);
   import sgr_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_START = 4'b0010,
      PH_HIGH  = 4'b0100,
      PH_LOW   = 4'b1000
   } phase_type;

   localparam int WIDE_BITS = ANGLE_PROD_BITS + ANGLE_FRAC_BITS;

   phase_type                phase_ff, phase_in;
   logic [TICK_BITS-1:0]     tick_ff, tick_in;
   logic [BITS_CNT_BITS-1:0] bits_ff, bits_in;
   logic [POSITION_BITS-1:0] shift_ff, shift_in;
   logic [CHAN_BITS-1:0]     active_ff, active_in;
   logic [CHANNELS-1:0]      clk_ff, clk_in;

   logic                     rsp_valid_ff;
   logic [CHANNELS-1:0]      rsp_clock_ff;
   logic                     rsp_busy_ff;
   logic                     rsp_done_ff, done;
   logic [CHAN_BITS-1:0]     rsp_chan_ff, done_chan;
   logic [POSITION_BITS-1:0] rsp_pos_ff, position;
   logic [ANGLE_BITS-1:0]    rsp_angle_ff, angle;
   logic                     rsp_refused_ff, refused;

   logic                     advance;
   logic [TICK_BITS-1:0]     start_prod, half_prod, start_dur, half_dur, tick_dec;
   logic [CHANNELS-1:0]      cbit;
   logic                     data_bit;
   logic [ANGLE_PROD_BITS-1:0] angle_prod;
   logic [WIDE_BITS-1:0]     angle_wide;
   logic [ANGLE_BITS-1:0]    angle_raw;

   assign advance = cmd_valid && (!rsp_valid_ff || rsp_bus.ready);
   assign pop     = advance;

   // Phase durations; a zero product counts as one tick
   assign start_prod = TICK_BITS'(cfg.unit_ticks) * TICK_BITS'(cfg.start_units);
   assign half_prod  = TICK_BITS'(cfg.unit_ticks) * TICK_BITS'(cfg.half_units);
   assign start_dur  = (start_prod == '0) ? TICK_BITS'(1) : start_prod;
   assign half_dur   = (half_prod == '0) ? TICK_BITS'(1) : half_prod;
   assign tick_dec   = (tick_ff != '0) ? tick_ff - TICK_BITS'(1) : '0;

   assign cbit     = CHANNELS'(1) << active_ff;
   assign data_bit = cmd.data_lines[active_ff];

   // Shift word already holds binary; scale to 1/65536 degree
   assign angle_prod = ANGLE_PROD_BITS'(shift_ff) * ANGLE_PROD_BITS'(ANGLE_SCALE);
   assign angle_wide = {angle_prod, {ANGLE_FRAC_BITS{1'b0}}} >> POSITION_BITS;
   assign angle_raw  = angle_wide[ANGLE_BITS-1:0];

   always_comb begin
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      bits_in   = bits_ff;
      shift_in  = shift_ff;
      active_in = active_ff;
      clk_in    = clk_ff;
      refused   = 1'b0;
      done      = 1'b0;
      done_chan = '0;
      position  = '0;
      angle     = '0;

      if (phase_ff != PH_IDLE) begin
         refused = cmd.is_start;
         tick_in = tick_dec;
      end

      case (phase_ff)
         PH_IDLE: begin
            if (cmd.is_start && cmd.chan_ok) begin
               active_in = cmd.channel;
               clk_in    = clk_ff & ~(CHANNELS'(1) << cmd.channel);
               phase_in  = PH_START;
               tick_in   = start_dur;
               bits_in   = BITS_CNT_BITS'(POSITION_BITS);
               shift_in  = '0;
            end
         end
         PH_START: begin
            if (tick_dec == '0) begin
               clk_in   = clk_ff | cbit;
               phase_in = PH_HIGH;
               tick_in  = half_dur;
            end
         end
         PH_HIGH: begin
            if (tick_dec == '0) begin
               // Falling edge: sample and fold the Gray bit into binary
               clk_in   = clk_ff & ~cbit;
               shift_in = {shift_ff[POSITION_BITS-2:0], shift_ff[0] ^ data_bit};
               if (bits_ff != '0) begin
                  bits_in = bits_ff - BITS_CNT_BITS'(1);
               end
               phase_in = PH_LOW;
               tick_in  = half_dur;
            end
         end
         PH_LOW: begin
            if (tick_dec == '0) begin
               clk_in = clk_ff | cbit;
               if (bits_ff == '0) begin
                  done      = 1'b1;
                  done_chan = active_ff;
                  position  = shift_ff;
                  angle     = cfg.invert_mask[active_ff] ? FULL_TURN - angle_raw : angle_raw;
                  phase_in  = PH_IDLE;
                  tick_in   = '0;
               end else begin
                  phase_in = PH_HIGH;
                  tick_in  = half_dur;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_ff      <= '0;
         bits_ff      <= '0;
         shift_ff     <= '0;
         active_ff    <= '0;
         clk_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            phase_ff  <= phase_in;
            tick_ff   <= tick_in;
            bits_ff   <= bits_in;
            shift_ff  <= shift_in;
            active_ff <= active_in;
            clk_ff    <= clk_in;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_clock_ff   <= clk_in;
         rsp_busy_ff    <= (phase_in != PH_IDLE);
         rsp_done_ff    <= done;
         rsp_chan_ff    <= done_chan;
         rsp_pos_ff     <= position;
         rsp_angle_ff   <= angle;
         rsp_refused_ff <= refused;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.clock_lines   = rsp_clock_ff;
   assign rsp_bus.busy_res      = rsp_busy_ff;
   assign rsp_bus.done_res      = rsp_done_ff;
   assign rsp_bus.done_channel  = rsp_chan_ff;
   assign rsp_bus.position      = rsp_pos_ff;
   assign rsp_bus.angle         = rsp_angle_ff;
   assign rsp_bus.start_refused = rsp_refused_ff;

endmodule

@@ rtl/ssi_gray_encoder_reader_core.sv @@
// SSI master for eight Gray-coded absolute encoders.
// Request channel (req_bus): each item is either one timing tick (op 0) or a
//   start of a read on the named channel (op 1). Every item carries the
//   sampled data pin levels of all channels.
// Response channel (rsp_bus): exactly one item per request item, in order,
//   with the driven clock pin levels, busy flag, and on the finishing item
//   the channel, binary position and angle (1/65536 degree, mirrored for
//   channels set in invert_mask). A start while a read runs is flagged.
// Configuration (csr_we, csr_index, csr_wdata): unit_ticks, start_units,
//   half_units, invert_mask; write only while the block is idle.
// Throughput: one item per clock while no response is held. The request
//   lands in the two-entry command queue, and the sequencer takes it from the
//   queue's head and registers its response.
// Stall: a held response stops the sequencer; the queue then fills and
//   req_bus.ready drops once both entries hold items, after at most two
//   more items.
// Reset: all clock lines low, no read in progress, queue empty, registers
//   back to their reset values.
module ssi_gray_encoder_reader_core (
   input  logic                               clock,
   input  logic                               reset,
   sgr_req_if.sink                            req_bus,
   sgr_rsp_if.source                          rsp_bus,
   input  logic                               csr_we,
   input  logic [sgr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sgr_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import sgr_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    push, queue_full, pop, cmd_valid;
   cmd_type push_cmd, cmd;

   // Configuration registers; writes are simply taken, no handshake
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_UNIT_TICKS:  cfg_in.unit_ticks  = csr_wdata[UNIT_BITS-1:0];
            CSR_START_UNITS: cfg_in.start_units = csr_wdata[UNITS_BITS-1:0];
            CSR_HALF_UNITS:  cfg_in.half_units  = csr_wdata[UNITS_BITS-1:0];
            CSR_INVERT_MASK: cfg_in.invert_mask = csr_wdata[CHANNELS-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.unit_ticks  <= UNIT_TICKS_RESET;
         cfg_ff.start_units <= START_UNITS_RESET;
         cfg_ff.half_units  <= HALF_UNITS_RESET;
         cfg_ff.invert_mask <= INVERT_MASK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: accept and classify
   sgr_front u_front (
      .req_bus    (req_bus),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // Decouple front and sequencer
   sgr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (pop),
      .out_valid (cmd_valid),
      .out_cmd   (cmd)
   );

   // Back: clock sequencer, shift-in, decode and response register
   sgr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .pop       (pop),
      .rsp_bus   (rsp_bus)
   );

   // A finishing item leaves the block idle
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.done_res) |-> !rsp_bus.busy_res)
      else $error("read finished but busy still set");

   // The finished channel's clock line returns high
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.done_res) |-> rsp_bus.clock_lines[rsp_bus.done_channel])
      else $error("clock line not high at end of read");

   // Result fields stay zero unless a read finishes
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.done_res) |->
         (rsp_bus.position == '0 && rsp_bus.angle == '0 && rsp_bus.done_channel == '0))
      else $error("result fields set without a finished read");

   // A refused start can only occur while a read runs
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.start_refused) |-> (rsp_bus.busy_res || rsp_bus.done_res))
      else $error("start refused while idle");

endmodule
